/* src/ps2mt_pkg.sv */
// ps2mt_pkg: shared types and constants for the ps/2 mouse packet tracker
// no dependencies; used by ps2_mouse_packet_tracker
`timescale 1ns / 1ps

package ps2mt_pkg;

  // payload widths fixed by the packet and result formats
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned POS_W       = 12;
  localparam int unsigned BTN_W       = 3;
  localparam int unsigned OUT_DATA_W  = 32;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 12;

  // default coordinate register width
  localparam int unsigned COORD_BITS_DEF = 12;

  // cursor home position after reset
  localparam int unsigned HOME_X = 320;
  localparam int unsigned HOME_Y = 240;

  // flag byte bit positions
  localparam int unsigned SYNC_BIT   = 3;
  localparam int unsigned X_SIGN_BIT = 4;
  localparam int unsigned Y_SIGN_BIT = 5;
  localparam int unsigned X_OVF_BIT  = 6;
  localparam int unsigned Y_OVF_BIT  = 7;

  // reset value of both maximum registers
  localparam logic [CFG_DATA_W-1:0] MAX_RST = '1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_X = 1'b0,
    REG_MAX_Y = 1'b1
  } cfg_reg_t;

  // position within the three-byte packet
  typedef enum logic [1:0] {
    PH_FLAG = 2'd0,
    PH_DX   = 2'd1,
    PH_DY   = 2'd2
  } phase_t;

endpackage

/* src/ps2_mouse_packet_tracker.sv */
// ps2_mouse_packet_tracker: assembles ps/2 mouse packets and tracks a clamped cursor
// depends on ps2mt_pkg
`timescale 1ns / 1ps

// Takes one mouse byte per cycle and, on the third byte of each good packet,
// produces one result item with the cursor position and button state. Every
// byte is handled in the cycle it is accepted; the only register between input
// and output is the result register: one byte per clock while results drain.
// Flag and x-movement bytes are accepted even while a result waits on the
// output; the closing y byte waits until the result register is free. First
// bytes without the sync bit are dropped, and packets with an overflow flag
// are swallowed without a result. Cursor x and y are clamped to 0..max_x and
// 0..max_y (also capped at the coordinate register range); a lowered maximum
// takes effect at the next good packet. Configuration writes are taken every
// cycle and should only be issued while the block is idle.
module ps2_mouse_packet_tracker #(
  parameter int unsigned COORD_BITS = ps2mt_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input byte stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [ps2mt_pkg::BYTE_W-1:0]       in_tdata,   // [7:0] rx_byte
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [ps2mt_pkg::OUT_DATA_W-1:0]   out_tdata,  // [11:0] pos_x, [23:12] pos_y,
                                                         // [26:24] button_bits, rest zero
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ps2mt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ps2mt_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int unsigned POS_W  = ps2mt_pkg::POS_W;
  localparam int unsigned BTN_W  = ps2mt_pkg::BTN_W;
  localparam int unsigned BYTE_W = ps2mt_pkg::BYTE_W;
  // arithmetic width: wide enough for cursor plus or minus a 9-bit delta
  localparam int unsigned WIDE_W = ((COORD_BITS > POS_W) ? COORD_BITS : POS_W) + 2;
  localparam int unsigned COORD_MAX = (1 << COORD_BITS) - 1;
  localparam int unsigned HOME_X_SAT =
    (ps2mt_pkg::HOME_X > COORD_MAX) ? COORD_MAX : ps2mt_pkg::HOME_X;
  localparam int unsigned HOME_Y_SAT =
    (ps2mt_pkg::HOME_Y > COORD_MAX) ? COORD_MAX : ps2mt_pkg::HOME_Y;
  localparam int unsigned PAD_W = ps2mt_pkg::OUT_DATA_W - 2 * POS_W - BTN_W;

  // state
  ps2mt_pkg::phase_t                  phase_r, phase_nxt;
  logic [BYTE_W-1:0]                  flag_r, flag_nxt;
  logic [BYTE_W-1:0]                  dx_byte_r, dx_byte_nxt;
  logic [COORD_BITS-1:0]              cur_x_r, cur_x_nxt;
  logic [COORD_BITS-1:0]              cur_y_r, cur_y_nxt;
  logic [ps2mt_pkg::CFG_DATA_W-1:0]   max_x_r, max_y_r;

  // result register
  logic                               out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]                   out_x_r, out_x_nxt;
  logic [POS_W-1:0]                   out_y_r, out_y_nxt;
  logic [BTN_W-1:0]                   out_btn_r, out_btn_nxt;

  // datapath
  logic                               accept;
  logic                               emit;
  logic signed [WIDE_W-1:0]           dx_w, dy_w, sum_x, sum_y;
  logic signed [WIDE_W-1:0]           lim_x, lim_y;
  logic [COORD_BITS-1:0]              new_x, new_y;

  // y byte needs a free result slot, the other bytes never do
  assign in_tready = (phase_r != ps2mt_pkg::PH_DY) || !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_btn_r, out_y_r, out_x_r};

  // effective limits: max register capped at the coordinate range
  assign lim_x = (WIDE_W'(max_x_r) > WIDE_W'(COORD_MAX)) ? WIDE_W'(COORD_MAX)
                                                         : WIDE_W'(max_x_r);
  assign lim_y = (WIDE_W'(max_y_r) > WIDE_W'(COORD_MAX)) ? WIDE_W'(COORD_MAX)
                                                         : WIDE_W'(max_y_r);

  // 9-bit movement deltas, sign taken from the flag byte
  assign dx_w = WIDE_W'($signed({flag_r[ps2mt_pkg::X_SIGN_BIT], dx_byte_r}));
  assign dy_w = WIDE_W'($signed({flag_r[ps2mt_pkg::Y_SIGN_BIT], in_tdata}));

  // x adds, y subtracts (screen y grows downward)
  assign sum_x = $signed(WIDE_W'(cur_x_r)) + dx_w;
  assign sum_y = $signed(WIDE_W'(cur_y_r)) - dy_w;

  // clamp to 0..limit
  always_comb begin
    if (sum_x[WIDE_W-1]) begin
      new_x = '0;
    end else if (sum_x > lim_x) begin
      new_x = COORD_BITS'(lim_x);
    end else begin
      new_x = COORD_BITS'(sum_x);
    end
    if (sum_y[WIDE_W-1]) begin
      new_y = '0;
    end else if (sum_y > lim_y) begin
      new_y = COORD_BITS'(lim_y);
    end else begin
      new_y = COORD_BITS'(sum_y);
    end
  end

  // packet sequencing and result capture
  always_comb begin
    phase_nxt     = phase_r;
    flag_nxt      = flag_r;
    dx_byte_nxt   = dx_byte_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    emit          = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_btn_nxt   = out_btn_r;
    if (accept) begin
      case (phase_r)
        ps2mt_pkg::PH_FLAG: begin
          // drop bytes without the sync bit
          if (in_tdata[ps2mt_pkg::SYNC_BIT]) begin
            flag_nxt  = in_tdata;
            phase_nxt = ps2mt_pkg::PH_DX;
          end
        end
        ps2mt_pkg::PH_DX: begin
          dx_byte_nxt = in_tdata;
          phase_nxt   = ps2mt_pkg::PH_DY;
        end
        ps2mt_pkg::PH_DY: begin
          phase_nxt = ps2mt_pkg::PH_FLAG;
          // overflow packets are swallowed
          emit = !flag_r[ps2mt_pkg::X_OVF_BIT] && !flag_r[ps2mt_pkg::Y_OVF_BIT];
        end
        default: begin
          phase_nxt = ps2mt_pkg::PH_FLAG;
        end
      endcase
    end
    if (emit) begin
      cur_x_nxt     = new_x;
      cur_y_nxt     = new_y;
      out_valid_nxt = 1'b1;
      out_x_nxt     = POS_W'(new_x);
      out_y_nxt     = POS_W'(new_y);
      out_btn_nxt   = flag_r[BTN_W-1:0];
    end
  end

  // control and cursor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= ps2mt_pkg::PH_FLAG;
      flag_r      <= '0;
      dx_byte_r   <= '0;
      cur_x_r     <= COORD_BITS'(HOME_X_SAT);
      cur_y_r     <= COORD_BITS'(HOME_Y_SAT);
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      flag_r      <= flag_nxt;
      dx_byte_r   <= dx_byte_nxt;
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_x_r   <= out_x_nxt;
    out_y_r   <= out_y_nxt;
    out_btn_r <= out_btn_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_x_r <= ps2mt_pkg::MAX_RST;
      max_y_r <= ps2mt_pkg::MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (ps2mt_pkg::cfg_reg_t'(cfg_index))
        ps2mt_pkg::REG_MAX_X: max_x_r <= cfg_data;
        ps2mt_pkg::REG_MAX_Y: max_y_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

/* bench/tb_ps2_mouse_packet_tracker.sv */
// tb_ps2_mouse_packet_tracker: self-checking bench for the ps/2 mouse packet tracker
// tracks packet phase and clamped cursor in the bench and checks every result item
// depends on ps2mt_pkg and ps2_mouse_packet_tracker
`timescale 1ns / 1ps

module tb_ps2_mouse_packet_tracker;
  import ps2mt_pkg::*;

  localparam int COORD_MAX = (1 << COORD_BITS_DEF) - 1;
  localparam int PAD_LSB   = 2 * POS_W + BTN_W;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [BYTE_W-1:0]     in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ps2_mouse_packet_tracker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // one expected cursor report
  typedef struct {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [BTN_W-1:0] buttons;
  } cursor_report_t;

  cursor_report_t pending_reports[$];

  // bench copy of the tracker state and limit registers
  phase_t                pkt_phase;
  logic [BYTE_W-1:0]     flag_q;
  logic [BYTE_W-1:0]     dx_q;
  int                    cursor_x;
  int                    cursor_y;
  logic [CFG_DATA_W-1:0] lim_x;
  logic [CFG_DATA_W-1:0] lim_y;

  int  mismatches = 0;
  int  bytes_sent = 0;
  int  reports_checked = 0;
  int  overflow_drops = 0;
  int  sync_drops = 0;
  bit  steady_link = 1'b0;

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop if something hangs
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int coord_limit(logic [CFG_DATA_W-1:0] r);
    return (int'(r) > COORD_MAX) ? COORD_MAX : int'(r);
  endfunction

  function automatic int clamp_coord(int v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // advance the packet state by one byte, queue a report when a packet scores
  task automatic track_byte(input logic [BYTE_W-1:0] b);
    int dx;
    int dy;
    cursor_report_t r;
    case (pkt_phase)
      PH_FLAG: begin
        if (b[SYNC_BIT]) begin
          flag_q    = b;
          pkt_phase = PH_DX;
        end else begin
          sync_drops++;
        end
      end
      PH_DX: begin
        dx_q      = b;
        pkt_phase = PH_DY;
      end
      default: begin
        pkt_phase = PH_FLAG;
        if (flag_q[X_OVF_BIT] || flag_q[Y_OVF_BIT]) begin
          overflow_drops++;
        end else begin
          dx = int'(dx_q) - (flag_q[X_SIGN_BIT] ? 256 : 0);
          dy = int'(b) - (flag_q[Y_SIGN_BIT] ? 256 : 0);
          cursor_x = clamp_coord(cursor_x + dx, coord_limit(lim_x));
          cursor_y = clamp_coord(cursor_y - dy, coord_limit(lim_y));
          r.pos_x   = cursor_x[POS_W-1:0];
          r.pos_y   = cursor_y[POS_W-1:0];
          r.buttons = flag_q[BTN_W-1:0];
          pending_reports.push_back(r);
        end
      end
    endcase
  endtask

  // result checker with random back-pressure
  always @(posedge clk) begin
    cursor_report_t exp_r;
    out_tready <= steady_link ? 1'b1 : ($urandom_range(0, 99) >= 21);
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_reports.size() == 0) begin
        report_mismatch($sformatf("unexpected result tdata=%h", out_tdata));
      end else begin
        exp_r = pending_reports.pop_front();
        reports_checked++;
        if (out_tdata[POS_W-1:0] !== exp_r.pos_x)
          report_mismatch($sformatf("pos_x got %0d want %0d",
                                    out_tdata[POS_W-1:0], exp_r.pos_x));
        if (out_tdata[2*POS_W-1:POS_W] !== exp_r.pos_y)
          report_mismatch($sformatf("pos_y got %0d want %0d",
                                    out_tdata[2*POS_W-1:POS_W], exp_r.pos_y));
        if (out_tdata[PAD_LSB-1:2*POS_W] !== exp_r.buttons)
          report_mismatch($sformatf("button_bits got %b want %b",
                                    out_tdata[PAD_LSB-1:2*POS_W], exp_r.buttons));
        if (out_tdata[OUT_DATA_W-1:PAD_LSB] !== '0)
          report_mismatch($sformatf("padding bits not zero, tdata=%h", out_tdata));
      end
    end
  end

  // send one byte, each cycle in front of it idles with a fixed chance
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while (!steady_link && $urandom_range(0, 99) < 21) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    track_byte(b);
  endtask

  task automatic send_packet(input logic [BYTE_W-1:0] flag, dx, dy);
    send_byte(flag);
    send_byte(dx);
    send_byte(dy);
  endtask

  // stop sending and let every expected report drain
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write both limit registers back to back
  task automatic set_limits(input logic [CFG_DATA_W-1:0] mx, my);
    cfg_valid <= 1'b1;
    cfg_index <= REG_MAX_X;
    cfg_data  <= mx;
    do @(posedge clk); while (!cfg_ready);
    lim_x = mx;
    cfg_index <= REG_MAX_Y;
    cfg_data  <= my;
    do @(posedge clk); while (!cfg_ready);
    lim_y = my;
    cfg_valid <= 1'b0;
  endtask

  // sync loss, zero and extreme moves, every overflow combination
  task automatic test_directed_cases();
    send_byte(8'h00);
    send_byte(8'hF7);
    send_packet(8'h08, 8'h00, 8'h00);
    send_packet(8'h0F, 8'hFF, 8'h00);
    send_packet(8'h38, 8'h00, 8'h00);
    send_packet(8'h48, 8'h01, 8'h01);
    send_packet(8'h88, 8'h7F, 8'h80);
    send_packet(8'hCF, 8'hFF, 8'hFF);
    send_packet(8'h0A, 8'h00, 8'hFF);
    wait_idle();
  endtask

  // clamping at both ends, lowered maximum below the cursor, zero range
  task automatic test_clamp_limits();
    set_limits(12'hFFF, 12'hFFF);
    repeat (18) send_packet(8'h28, 8'hFF, 8'h01);
    wait_idle();
    set_limits(12'd1000, 12'd700);
    send_packet(8'h08, 8'h00, 8'h00);
    wait_idle();
    set_limits(12'hFFF, 12'hFFF);
    repeat (18) send_packet(8'h1F, 8'h01, 8'hFF);
    wait_idle();
    set_limits(12'd0, 12'd0);
    send_packet(8'h09, 8'h7F, 8'h80);
    send_packet(8'h3A, 8'h80, 8'h80);
    wait_idle();
  endtask

  // mostly well-formed packets, some noise and truncated packets
  task automatic random_traffic(input int n_steps);
    logic [BYTE_W-1:0] fb;
    int pick;
    for (int i = 0; i < n_steps; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_byte(BYTE_W'($urandom));
      end else if (pick < 12) begin
        fb = BYTE_W'($urandom);
        fb[SYNC_BIT] = 1'b1;
        send_byte(fb);
        if ($urandom_range(0, 1)) send_byte(BYTE_W'($urandom));
      end else begin
        fb = BYTE_W'($urandom);
        fb[SYNC_BIT] = 1'b1;
        if ($urandom_range(0, 9) != 0) begin
          fb[X_OVF_BIT] = 1'b0;
          fb[Y_OVF_BIT] = 1'b0;
        end
        send_packet(fb, BYTE_W'($urandom), BYTE_W'($urandom));
      end
    end
  endtask

  // several limit settings, one phase with both sides running flat out
  task automatic test_random_streams();
    set_limits(12'hFFF, 12'hFFF);
    random_traffic(105);
    wait_idle();
    set_limits(12'd639, 12'd479);
    random_traffic(105);
    wait_idle();
    set_limits(12'd0, 12'hFFF);
    random_traffic(60);
    wait_idle();
    steady_link = 1'b1;
    set_limits(CFG_DATA_W'($urandom_range(0, 4095)), CFG_DATA_W'($urandom_range(0, 4095)));
    random_traffic(110);
    wait_idle();
    steady_link = 1'b0;
    set_limits(CFG_DATA_W'($urandom_range(0, 300)), CFG_DATA_W'($urandom_range(0, 300)));
    random_traffic(105);
    wait_idle();
    set_limits(CFG_DATA_W'($urandom_range(0, 4095)), 12'd0);
    random_traffic(60);
    wait_idle();
    set_limits(CFG_DATA_W'($urandom_range(0, 4095)), CFG_DATA_W'($urandom_range(0, 4095)));
    random_traffic(90);
    wait_idle();
  endtask

  initial begin
    pkt_phase = PH_FLAG;
    flag_q    = '0;
    dx_q      = '0;
    lim_x     = MAX_RST;
    lim_y     = MAX_RST;
    cursor_x  = (int'(HOME_X) > COORD_MAX) ? COORD_MAX : int'(HOME_X);
    cursor_y  = (int'(HOME_Y) > COORD_MAX) ? COORD_MAX : int'(HOME_Y);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_clamp_limits();
    test_random_streams();

    wait_idle();
    repeat (8) @(posedge clk);
    $display("sent %0d bytes, checked %0d cursor reports", bytes_sent, reports_checked);
    $display("dropped %0d unsynced first bytes and %0d overflow packets",
             sync_drops, overflow_drops);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
